// File: rtl/rbst_pkg.sv
`timescale 1ns / 1ps
// Package for the ray/box slab test: item types, stage map, pipeline control struct.
// No dependencies.
package rbst_pkg;

   localparam int WORD_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DIFF_W            = WORD_W + 1;
   localparam int PROD_W            = DIFF_W + WORD_W;

   localparam int NUM_STAGES = 5;
   localparam int ST_DIFF    = 0;
   localparam int ST_MUL     = 1;
   localparam int ST_RND     = 2;
   localparam int ST_MINMAX  = 3;
   localparam int ST_OUT     = 4;

   localparam logic signed [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [WORD_W-1:0] origin_x;
      logic signed [WORD_W-1:0] origin_y;
      logic signed [WORD_W-1:0] origin_z;
      logic signed [WORD_W-1:0] inv_dir_x;
      logic signed [WORD_W-1:0] inv_dir_y;
      logic signed [WORD_W-1:0] inv_dir_z;
      logic signed [WORD_W-1:0] box_lo_x;
      logic signed [WORD_W-1:0] box_lo_y;
      logic signed [WORD_W-1:0] box_lo_z;
      logic signed [WORD_W-1:0] box_hi_x;
      logic signed [WORD_W-1:0] box_hi_y;
      logic signed [WORD_W-1:0] box_hi_z;
   } req_item_type;

   typedef struct packed {
      logic                     hit;
      logic signed [WORD_W-1:0] near_dist;
      logic signed [WORD_W-1:0] far_dist;
   } rsp_item_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctl_type;

endpackage

// File: rtl/rbst_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for ray items and slab test results.
// Depends on rbst_pkg.
interface rbst_req_if;
   logic                        valid;
   logic                        ready;
   rbst_pkg::req_item_type      item;
   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface rbst_rsp_if;
   logic                        valid;
   logic                        ready;
   rbst_pkg::rsp_item_type      item;
   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/ray_box_slab_test.sv
`timescale 1ns / 1ps
// Ray versus axis-aligned box slab test, top level.
// Depends on rbst_pkg, rbst_if, rbst_ctrl, rbst_axis, rbst_combine.
//
// Takes one ray/box item per cycle when the result side is not stalled
// and returns one result per item, in order. The pipeline is: corner minus
// origin, six 33x32 products (one register stage), round to FRAC_BITS and
// saturate to 32 bits, per-axis entry/exit ordering, then the near/far
// reduction and hit decision into the output register. Half-LSB rounding
// goes toward plus infinity; a miss returns zero distances;
// touching (near equal to far, or far equal to zero) is a hit. Each stage
// holds its item under backpressure, so bubbles are squeezed out and a new
// item is taken whenever any stage can move.
module ray_box_slab_test #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   rbst_req_if.sink          req_ch,
   rbst_rsp_if.source        rsp_ch
);

   rbst_pkg::stage_ctl_type            ctl;
   logic signed [rbst_pkg::WORD_W-1:0] entry_x, entry_y, entry_z;
   logic signed [rbst_pkg::WORD_W-1:0] exit_x, exit_y, exit_z;

   rbst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   rbst_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock     (clock),
      .ctl       (ctl),
      .origin    (req_ch.item.origin_x),
      .inv_dir   (req_ch.item.inv_dir_x),
      .box_lo    (req_ch.item.box_lo_x),
      .box_hi    (req_ch.item.box_hi_x),
      .entry     (entry_x),
      .exit_dist (exit_x)
   );

   rbst_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock     (clock),
      .ctl       (ctl),
      .origin    (req_ch.item.origin_y),
      .inv_dir   (req_ch.item.inv_dir_y),
      .box_lo    (req_ch.item.box_lo_y),
      .box_hi    (req_ch.item.box_hi_y),
      .entry     (entry_y),
      .exit_dist (exit_y)
   );

   rbst_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
      .clock     (clock),
      .ctl       (ctl),
      .origin    (req_ch.item.origin_z),
      .inv_dir   (req_ch.item.inv_dir_z),
      .box_lo    (req_ch.item.box_lo_z),
      .box_hi    (req_ch.item.box_hi_z),
      .entry     (entry_z),
      .exit_dist (exit_z)
   );

   rbst_combine u_combine (
      .clock   (clock),
      .ctl     (ctl),
      .entry_x (entry_x),
      .entry_y (entry_y),
      .entry_z (entry_z),
      .exit_x  (exit_x),
      .exit_y  (exit_y),
      .exit_z  (exit_z),
      .result  (rsp_ch.item)
   );

   // an empty output register means every stage can advance
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("input stalled with empty output stage");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.item.hit |->
         rsp_ch.item.near_dist == '0 && rsp_ch.item.far_dist == '0)
      else $error("miss item carries nonzero distances");

   a_hit_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.item.hit |->
         !rsp_ch.item.far_dist[rbst_pkg::WORD_W-1] &&
         rsp_ch.item.near_dist <= rsp_ch.item.far_dist)
      else $error("hit item with far behind origin or near past far");

   a_out_stage_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.item))
      else $error("stalled output item lost or changed");

endmodule

// File: rtl/rbst_ctrl.sv
`timescale 1ns / 1ps
// Pipeline valid bits and per-stage load enables with backpressure.
// Depends on rbst_pkg.
module rbst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rbst_pkg::stage_ctl_type ctl
);

   logic [rbst_pkg::NUM_STAGES-1:0] valid_ff;
   logic [rbst_pkg::NUM_STAGES-1:0] valid_in;

   always_comb begin
      ctl.load[rbst_pkg::ST_OUT] = !valid_ff[rbst_pkg::ST_OUT] || out_ready;
      for (int i = rbst_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         ctl.load[i] = !valid_ff[i] || ctl.load[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < rbst_pkg::NUM_STAGES; i++) begin
         if (ctl.load[i]) begin
            valid_in[i] = (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i-1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ctl.load[rbst_pkg::ST_DIFF];
   assign out_valid = valid_ff[rbst_pkg::ST_OUT];

endmodule

// File: rtl/rbst_axis.sv
`timescale 1ns / 1ps
// One axis: corner differences, products, round/saturate, entry/exit ordering.
// Depends on rbst_pkg; stages load on the enables from rbst_ctrl.
module rbst_axis #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  rbst_pkg::stage_ctl_type              ctl,
   input  logic signed [rbst_pkg::WORD_W-1:0]   origin,
   input  logic signed [rbst_pkg::WORD_W-1:0]   inv_dir,
   input  logic signed [rbst_pkg::WORD_W-1:0]   box_lo,
   input  logic signed [rbst_pkg::WORD_W-1:0]   box_hi,
   output logic signed [rbst_pkg::WORD_W-1:0]   entry,
   output logic signed [rbst_pkg::WORD_W-1:0]   exit_dist
);

   localparam int W  = rbst_pkg::WORD_W;
   localparam int DW = rbst_pkg::DIFF_W;
   localparam int PW = rbst_pkg::PROD_W;
   localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (FRAC_BITS - 1);

   logic signed [DW-1:0] diff_lo_ff, diff_hi_ff, diff_lo_in, diff_hi_in;
   logic signed [W-1:0]  inv_ff;
   logic signed [PW-1:0] prod_lo_ff, prod_hi_ff, prod_lo_in, prod_hi_in;
   logic signed [W-1:0]  ta_ff, tb_ff, ta_in, tb_in;
   logic signed [W-1:0]  entry_ff, exit_ff;

   function automatic logic signed [W-1:0] round_sat(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] r;
      r = (p + RND_HALF) >>> FRAC_BITS;
      if (&r[PW-1:W-1] || !(|r[PW-1:W-1])) begin
         round_sat = r[W-1:0];
      end else if (r[PW-1]) begin
         round_sat = rbst_pkg::S32_MIN;
      end else begin
         round_sat = rbst_pkg::S32_MAX;
      end
   endfunction

   assign diff_lo_in = DW'(box_lo) - DW'(origin);
   assign diff_hi_in = DW'(box_hi) - DW'(origin);
   assign prod_lo_in = PW'(diff_lo_ff) * PW'(inv_ff);
   assign prod_hi_in = PW'(diff_hi_ff) * PW'(inv_ff);
   assign ta_in      = round_sat(prod_lo_ff);
   assign tb_in      = round_sat(prod_hi_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[rbst_pkg::ST_DIFF]) begin
         diff_lo_ff <= diff_lo_in;
         diff_hi_ff <= diff_hi_in;
         inv_ff     <= inv_dir;
      end
      if (ctl.load[rbst_pkg::ST_MUL]) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (ctl.load[rbst_pkg::ST_RND]) begin
         ta_ff <= ta_in;
         tb_ff <= tb_in;
      end
      if (ctl.load[rbst_pkg::ST_MINMAX]) begin
         entry_ff <= (ta_ff < tb_ff) ? ta_ff : tb_ff;
         exit_ff  <= (ta_ff > tb_ff) ? ta_ff : tb_ff;
      end
   end

   assign entry     = entry_ff;
   assign exit_dist = exit_ff;

endmodule

// File: rtl/rbst_combine.sv
`timescale 1ns / 1ps
// Final stage: largest entry, smallest exit, hit decision, output register.
// Depends on rbst_pkg.
module rbst_combine (
   input  logic                               clock,
   input  rbst_pkg::stage_ctl_type            ctl,
   input  logic signed [rbst_pkg::WORD_W-1:0] entry_x,
   input  logic signed [rbst_pkg::WORD_W-1:0] entry_y,
   input  logic signed [rbst_pkg::WORD_W-1:0] entry_z,
   input  logic signed [rbst_pkg::WORD_W-1:0] exit_x,
   input  logic signed [rbst_pkg::WORD_W-1:0] exit_y,
   input  logic signed [rbst_pkg::WORD_W-1:0] exit_z,
   output rbst_pkg::rsp_item_type             result
);

   logic signed [rbst_pkg::WORD_W-1:0] near_xy, near_v, far_xy, far_v;
   logic                               hit;
   rbst_pkg::rsp_item_type             result_ff, result_in;

   always_comb begin
      near_xy = (entry_x > entry_y) ? entry_x : entry_y;
      near_v  = (near_xy > entry_z) ? near_xy : entry_z;
      far_xy  = (exit_x < exit_y) ? exit_x : exit_y;
      far_v   = (far_xy < exit_z) ? far_xy : exit_z;
      hit     = !far_v[rbst_pkg::WORD_W-1] && (near_v <= far_v);
      result_in.hit       = hit;
      result_in.near_dist = hit ? near_v : '0;
      result_in.far_dist  = hit ? far_v : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[rbst_pkg::ST_OUT]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
